### rtl/core/ljpf_pkg.sv
// ============================================================================
// ljpf_pkg
// Shared types, constants and fixed-point helpers for the LJ pair force block.
// ============================================================================
`default_nettype none

package ljpf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS  = 2 * FRAC_BITS + 1;

    localparam logic signed [63:0] S32MAX  = 64'sd2147483647;
    localparam logic signed [63:0] S32MIN  = -64'sd2147483648;
    localparam logic signed [63:0] FX_ONE  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] FX_HALF = 64'sd1 <<< (FRAC_BITS - 1);

    typedef enum logic [1:0] {
        CFG_BOX_X     = 2'd0,
        CFG_BOX_Y     = 2'd1,
        CFG_BOX_Z     = 2'd2,
        CFG_CUTOFF_SQ = 2'd3
    } cfg_idx_t;

    // Geometry of one pair after wrap and range test.
    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [30:0]        rr;
        logic               hit;
    } geo_t;

    // Clipped 32-bit value and its clip flag.
    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } fx_t;

    function automatic fx_t fx_clip(input logic signed [63:0] v);
        fx_t r;
        r.sat = 1'b0;
        if (v > S32MAX)
        begin
            r.val = S32MAX[31:0];
            r.sat = 1'b1;
        end
        else if (v < S32MIN)
        begin
            r.val = S32MIN[31:0];
            r.sat = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
        end
        return r;
    endfunction

    // Product scaled back by FRAC_BITS, truncated toward zero, then clipped.
    function automatic fx_t fx_scale(input logic signed [63:0] p);
        logic signed [63:0] sh;
        sh = p >>> FRAC_BITS;
        if (p[63] && (p[FRAC_BITS-1:0] != '0))
            sh = sh + 64'sd1;
        return fx_clip(sh);
    endfunction

    function automatic logic signed [63:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        ea = 64'(a);
        eb = 64'(b);
        return ea * eb;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ljpf_geom.sv
// ============================================================================
// ljpf_geom
// Displacement, minimum-image wrap, squared distance and cutoff test.
// ============================================================================
`default_nettype none

module ljpf_geom (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0][31:0]    pos_a,
    input  wire logic [2:0][31:0]    pos_b,
    input  wire logic [2:0][30:0]    box,
    input  wire logic [30:0]         cutoff_sq,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ljpf_pkg::geo_t           out_geo
);
    import ljpf_pkg::*;

    localparam int NS = 5;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    logic signed [32:0] diff_reg [3];
    logic signed [33:0] wrap_reg [3];
    logic signed [33:0] wrap_next [3];
    logic [30:0]        mag_reg [3];
    logic signed [31:0] d2_reg [3];
    logic               far2_reg;
    logic [33:0]        abs_next [3];
    logic [61:0]        sq_reg [3];
    logic signed [31:0] d3_reg [3];
    logic               far3_reg;
    geo_t               geo_reg;
    logic [63:0]        sum;
    logic [63:0]        rr_full;

    always_comb
    begin
        adv[NS-1] = ~v_reg[NS-1] | out_ready;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = ~v_reg[k] | adv[k+1];
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];
    assign out_geo   = geo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // wrap once against the box, and magnitude of the wrapped axis
    always_comb
    begin
        logic signed [33:0] ext;
        logic [33:0]        mag;
        logic signed [33:0] bx;
        for (int i = 0; i < 3; i++)
        begin
            ext = 34'(diff_reg[i]);
            mag = ext[33] ? 34'(-ext) : 34'(ext);
            bx  = signed'({3'b000, box[i]});
            wrap_next[i] = ext;
            if ({mag[32:0], 1'b0} > {3'b000, box[i]})
            begin
                if (ext > 34'sd0)
                    wrap_next[i] = ext - bx;
                else if (ext < 34'sd0)
                    wrap_next[i] = ext + bx;
            end
            abs_next[i] = wrap_reg[i][33] ? 34'(-wrap_reg[i]) : 34'(wrap_reg[i]);
        end
        sum = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        rr_full = sum >> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            for (int i = 0; i < 3; i++)
                diff_reg[i] <= 33'(signed'(pos_a[i])) - 33'(signed'(pos_b[i]));
        if (adv[1])
            for (int i = 0; i < 3; i++)
                wrap_reg[i] <= wrap_next[i];
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= abs_next[i][30:0];
                d2_reg[i]  <= wrap_reg[i][31:0];
            end
            far2_reg <= (|abs_next[0][33:31]) | (|abs_next[1][33:31])
                      | (|abs_next[2][33:31]);
        end
        if (adv[3])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= 62'(mag_reg[i]) * 62'(mag_reg[i]);
                d3_reg[i] <= d2_reg[i];
            end
            far3_reg <= far2_reg;
        end
        if (adv[4])
        begin
            geo_reg.dx  <= d3_reg[0];
            geo_reg.dy  <= d3_reg[1];
            geo_reg.dz  <= d3_reg[2];
            geo_reg.rr  <= rr_full[30:0];
            geo_reg.hit <= ~far3_reg && (rr_full < 64'(cutoff_sq));
        end
    end

endmodule

`default_nettype wire

### rtl/core/ljpf_recip.sv
// ============================================================================
// ljpf_recip
// Pipelined restoring divider: 2^(2*FRAC_BITS) / rr, one quotient bit a stage.
// ============================================================================
`default_nettype none

module ljpf_recip (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire ljpf_pkg::geo_t               in_geo,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output ljpf_pkg::geo_t                    out_geo,
    output logic [ljpf_pkg::DIV_BITS-1:0]     out_quo
);
    import ljpf_pkg::*;

    localparam int NS = DIV_BITS;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    geo_t                side_reg [NS];
    logic [31:0]         rem_reg  [NS];
    logic [DIV_BITS-1:0] quo_reg  [NS];

    always_comb
    begin
        adv[NS-1] = ~v_reg[NS-1] | out_ready;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = ~v_reg[k] | adv[k+1];
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];
    assign out_geo   = side_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_step
        geo_t                side_in;
        logic [31:0]         rem_in;
        logic [DIV_BITS-1:0] quo_in;
        logic [31:0]         trial;
        logic [31:0]         divisor;
        logic                take;

        if (k == 0)
        begin : g_first
            assign side_in = in_geo;
            assign rem_in  = '0;
            assign quo_in  = '0;
        end
        else
        begin : g_next
            assign side_in = side_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
        end

        // dividend is a single one in its top bit
        assign trial   = {rem_in[30:0], (k == 0) ? 1'b1 : 1'b0};
        assign divisor = {1'b0, side_in.rr};
        assign take    = (trial >= divisor);

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                side_reg[k] <= side_in;
                rem_reg[k]  <= take ? (trial - divisor) : trial;
                quo_reg[k]  <= {quo_in[DIV_BITS-2:0], take};
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/ljpf_kernel.sv
// ============================================================================
// ljpf_kernel
// LJ force, potential and virial from 1/r2 and the wrapped displacement.
// ============================================================================
`default_nettype none

module ljpf_kernel (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire ljpf_pkg::geo_t               in_geo,
    input  wire logic [ljpf_pkg::DIV_BITS-1:0] in_quo,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [31:0]                force_x,
    output logic signed [31:0]                force_y,
    output logic signed [31:0]                force_z,
    output logic signed [31:0]                potential,
    output logic signed [31:0]                virial,
    output logic                              in_range,
    output logic                              saturated
);
    import ljpf_pkg::*;

    localparam int NS = 9;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    // carried along every stage before the output register
    geo_t               geo_reg [NS-1];
    logic signed [31:0] rri_reg [NS-1];
    logic               sat_reg [NS-1];

    logic signed [63:0] p1_reg;
    logic signed [63:0] p2_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] th_reg;
    logic signed [31:0] to_reg;
    logic signed [63:0] p3_reg;
    logic signed [63:0] p4_reg;
    logic signed [63:0] p5_reg;
    logic signed [31:0] pot_reg [5:7];
    logic signed [31:0] fc_reg;
    logic signed [63:0] pf_reg [4];

    logic signed [31:0] force_x_reg;
    logic signed [31:0] force_y_reg;
    logic signed [31:0] force_z_reg;
    logic signed [31:0] pot_out_reg;
    logic signed [31:0] vir_reg;
    logic               hit_reg;
    logic               sat_out_reg;

    logic               rri_big;
    fx_t                s_a;
    fx_t                s_q;
    fx_t                s_th;
    fx_t                s_to;
    fx_t                s_b;
    fx_t                s_pm;
    fx_t                s_p4;
    fx_t                s_pot;
    fx_t                s_c;
    fx_t                s_fc;
    fx_t                s_f [4];
    logic               sat_f;

    always_comb
    begin
        adv[NS-1] = ~v_reg[NS-1] | out_ready;
        for (int k = NS - 2; k >= 0; k--)
            adv[k] = ~v_reg[k] | adv[k+1];
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[NS-1];
    assign force_x   = force_x_reg;
    assign force_y   = force_y_reg;
    assign force_z   = force_z_reg;
    assign potential = pot_out_reg;
    assign virial    = vir_reg;
    assign in_range  = hit_reg;
    assign saturated = sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    always_comb
    begin
        rri_big = (in_geo.rr == '0) || (64'(in_quo) > S32MAX);
        s_a   = fx_scale(p1_reg);
        s_q   = fx_scale(p2_reg);
        s_th  = fx_clip(64'(s_q.val) - FX_HALF);
        s_to  = fx_clip(64'(s_q.val) - FX_ONE);
        s_b   = fx_scale(p3_reg);
        s_pm  = fx_scale(p4_reg);
        s_p4  = fx_clip(64'(s_pm.val) <<< 2);
        s_pot = fx_clip(64'(s_p4.val) + FX_ONE);
        s_c   = fx_scale(p5_reg);
        s_fc  = fx_clip(64'(s_c.val) * 64'sd48);
        sat_f = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            s_f[i] = fx_scale(pf_reg[i]);
            sat_f  = sat_f | s_f[i].sat;
        end
    end

    always_ff @(posedge clk)
    begin
        // reciprocal clip
        if (adv[0])
        begin
            geo_reg[0] <= in_geo;
            rri_reg[0] <= rri_big ? S32MAX[31:0] : in_quo[31:0];
            sat_reg[0] <= rri_big;
        end
        for (int k = 1; k < NS - 1; k++)
        begin
            if (adv[k])
            begin
                geo_reg[k] <= geo_reg[k-1];
                rri_reg[k] <= rri_reg[k-1];
            end
        end
        if (adv[1])
        begin
            p1_reg     <= fx_mul(rri_reg[0], rri_reg[0]);
            sat_reg[1] <= sat_reg[0];
        end
        if (adv[2])
        begin
            p2_reg     <= fx_mul(s_a.val, rri_reg[1]);
            sat_reg[2] <= sat_reg[1] | s_a.sat;
        end
        if (adv[3])
        begin
            q_reg      <= s_q.val;
            th_reg     <= s_th.val;
            to_reg     <= s_to.val;
            sat_reg[3] <= sat_reg[2] | s_q.sat | s_th.sat | s_to.sat;
        end
        if (adv[4])
        begin
            p3_reg     <= fx_mul(q_reg, th_reg);
            p4_reg     <= fx_mul(q_reg, to_reg);
            sat_reg[4] <= sat_reg[3];
        end
        if (adv[5])
        begin
            p5_reg     <= fx_mul(s_b.val, rri_reg[4]);
            pot_reg[5] <= s_pot.val;
            sat_reg[5] <= sat_reg[4] | s_b.sat | s_pm.sat | s_p4.sat | s_pot.sat;
        end
        if (adv[6])
        begin
            fc_reg     <= s_fc.val;
            pot_reg[6] <= pot_reg[5];
            sat_reg[6] <= sat_reg[5] | s_c.sat | s_fc.sat;
        end
        if (adv[7])
        begin
            pf_reg[0]  <= fx_mul(fc_reg, geo_reg[6].dx);
            pf_reg[1]  <= fx_mul(fc_reg, geo_reg[6].dy);
            pf_reg[2]  <= fx_mul(fc_reg, geo_reg[6].dz);
            pf_reg[3]  <= fx_mul(fc_reg, signed'({1'b0, geo_reg[6].rr}));
            pot_reg[7] <= pot_reg[6];
            sat_reg[7] <= sat_reg[6];
        end
        // output register, zeros for pairs outside the cutoff
        if (adv[8])
        begin
            hit_reg     <= geo_reg[7].hit;
            force_x_reg <= geo_reg[7].hit ? s_f[0].val : '0;
            force_y_reg <= geo_reg[7].hit ? s_f[1].val : '0;
            force_z_reg <= geo_reg[7].hit ? s_f[2].val : '0;
            vir_reg     <= geo_reg[7].hit ? s_f[3].val : '0;
            pot_out_reg <= geo_reg[7].hit ? pot_reg[7] : '0;
            sat_out_reg <= geo_reg[7].hit & (sat_reg[7] | sat_f);
        end
    end

endmodule

`default_nettype wire

### rtl/core/lj_pair_force_periodic.sv
// ============================================================================
// lj_pair_force_periodic
// Shifted repulsive Lennard-Jones pair force with minimum-image wrap, Q16.16.
// ============================================================================
// One particle pair per transfer: positions a and b go in, the force on a,
// the shifted potential term, the virial term, an in-range bit and a
// saturation bit come out. The pipeline takes a new pair every clock unless a
// stalled output has backed it up to its input, and holds 47 pairs in flight:
// 5 stages for displacement, wrap and squared distance, 33 stages for the
// reciprocal (one quotient bit per stage of a restoring divider, 2*FRAC_BITS+1
// in all), and 9 stages for the multiply chain ending in the output register.
// Each stage has its own valid bit and moves whenever it is empty or the stage
// after it moves, so a stalled output only fills the pipe and never drops a pair.
// Box lengths and the squared cutoff are written through the config port
// (always ready); change them only while no pair is in flight.
// Pairs beyond the cutoff give all-zero results with both flags low.
// ============================================================================
`default_nettype none

module lj_pair_force_periodic (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire ljpf_pkg::cfg_idx_t     cfg_index,
    input  wire logic [30:0]            cfg_data,
    // pair input
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [31:0]     ax,
    input  wire logic signed [31:0]     ay,
    input  wire logic signed [31:0]     az,
    input  wire logic signed [31:0]     bx,
    input  wire logic signed [31:0]     by,
    input  wire logic signed [31:0]     bz,
    // result output
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [31:0]          force_x,
    output logic signed [31:0]          force_y,
    output logic signed [31:0]          force_z,
    output logic signed [31:0]          potential,
    output logic signed [31:0]          virial,
    output logic                        in_range,
    output logic                        saturated
);
    import ljpf_pkg::*;

    logic [30:0] box_x_reg;
    logic [30:0] box_y_reg;
    logic [30:0] box_z_reg;
    logic [30:0] cutoff_sq_reg;

    logic                geo_valid;
    logic                geo_ready;
    geo_t                geo;
    logic                div_valid;
    logic                div_ready;
    geo_t                div_geo;
    logic [DIV_BITS-1:0] div_quo;

    assign cfg_ready = 1'b1;

    // register file; every write transfer lands at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg     <= 31'd732712;
            box_y_reg     <= 31'd732712;
            box_z_reg     <= 31'd732712;
            cutoff_sq_reg <= 31'd82570;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BOX_X:     box_x_reg     <= cfg_data;
                CFG_BOX_Y:     box_y_reg     <= cfg_data;
                CFG_BOX_Z:     box_z_reg     <= cfg_data;
                CFG_CUTOFF_SQ: cutoff_sq_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // displacement, wrap, squared distance, cutoff test
    ljpf_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_a     ({az, ay, ax}),
        .pos_b     ({bz, by, bx}),
        .box       ({box_z_reg, box_y_reg, box_x_reg}),
        .cutoff_sq (cutoff_sq_reg),
        .out_valid (geo_valid),
        .out_ready (geo_ready),
        .out_geo   (geo)
    );

    // 1/r2 divider
    ljpf_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geo_valid),
        .in_ready  (geo_ready),
        .in_geo    (geo),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_geo   (div_geo),
        .out_quo   (div_quo)
    );

    // force, potential and virial; owns the output register
    ljpf_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_geo    (div_geo),
        .in_quo    (div_quo),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .force_x   (force_x),
        .force_y   (force_y),
        .force_z   (force_z),
        .potential (potential),
        .virial    (virial),
        .in_range  (in_range),
        .saturated (saturated)
    );

endmodule

`default_nettype wire

### bench/tb.sv
// ============================================================================
// tb
// Stream test of the minimum-image Lennard-Jones pair force block.
// Pairs go in through a handshake that idles at random, and results come out
// through a receiver that stalls at random. A scoreboard keeps its own copy
// of the box and cutoff registers, predicts every result from the pair, and
// compares the results field by field in arrival order.
// ============================================================================
`default_nettype none

module tb;

    import ljpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transfer anywhere
    localparam int DRAIN_CYCLES   = 60;    // pipeline is 47 deep
    localparam int HOLD_CYCLES    = 800;   // long receiver hold-off, fills the pipe

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic signed [31:0] pot;
        logic signed [31:0] vir;
        logic               hit;
        logic               sat;
    } pair_result_t;

    // Keeps the register copy, predicts each pair and checks results in order.
    class pair_force_board;
        longint unsigned box[3];
        longint unsigned cut_sq;
        pair_result_t    expected_q[$];
        int              mismatches;
        int              pairs_seen;
        int              hits_seen;
        int              sats_seen;

        function new();
            box[0] = 732712;
            box[1] = 732712;
            box[2] = 732712;
            cut_sq = 82570;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [30:0] v);
            case (idx)
                CFG_BOX_X:     box[0] = 64'(v);
                CFG_BOX_Y:     box[1] = 64'(v);
                CFG_BOX_Z:     box[2] = 64'(v);
                CFG_CUTOFF_SQ: cut_sq = 64'(v);
            endcase
        endfunction

        function longint clip(longint v, inout bit s);
            if (v > 64'sd2147483647)
            begin
                s = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                s = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // fixed-point product, truncated toward zero
        function longint fxmul(longint a, longint b, inout bit s);
            longint p;
            longint unsigned m;
            p = a * b;
            m = (p < 0) ? longint'(-p) : p;
            m = m >> FRAC_BITS;
            return clip((p < 0) ? -longint'(m) : longint'(m), s);
        endfunction

        function void note_pair(logic signed [31:0] a[3], logic signed [31:0] b[3]);
            pair_result_t r;
            longint d[3];
            longint unsigned mag;
            longint unsigned sum;
            longint rr, rri, q, fc, pot, t;
            bit far;
            bit s;
            sum = 0;
            far = 0;
            s = 0;
            r = '{default: '0};
            for (int i = 0; i < 3; i++)
            begin
                d[i] = longint'(a[i]) - longint'(b[i]);
                mag = (d[i] < 0) ? longint'(-d[i]) : d[i];
                // wrap once against the box, zero displacement never moves
                if (2 * mag > box[i])
                begin
                    if (d[i] > 0)
                        d[i] = d[i] - longint'(box[i]);
                    else if (d[i] < 0)
                        d[i] = d[i] + longint'(box[i]);
                end
                mag = (d[i] < 0) ? longint'(-d[i]) : d[i];
                if (mag >= 64'h8000_0000)
                    far = 1;
                else
                    sum += mag * mag;
            end
            pairs_seen++;
            rr = longint'(sum >> FRAC_BITS);
            if (!far && longint'(rr) < longint'(cut_sq))
            begin
                if (rr == 0)
                begin
                    rri = 64'sd2147483647;
                    s = 1;
                end
                else
                    rri = clip(longint'((64'd1 << (2 * FRAC_BITS)) / rr), s);
                q   = fxmul(fxmul(rri, rri, s), rri, s);
                t   = clip(q - (64'sd1 <<< (FRAC_BITS - 1)), s);
                fc  = fxmul(fxmul(q, t, s), rri, s);
                fc  = clip(48 * fc, s);
                t   = clip(q - (64'sd1 <<< FRAC_BITS), s);
                pot = clip(4 * fxmul(q, t, s), s);
                pot = clip(pot + (64'sd1 <<< FRAC_BITS), s);
                r.vir = 32'(fxmul(fc, rr, s));
                r.fx  = 32'(fxmul(fc, d[0], s));
                r.fy  = 32'(fxmul(fc, d[1], s));
                r.fz  = 32'(fxmul(fc, d[2], s));
                r.pot = 32'(pot);
                r.hit = 1;
                r.sat = s;
                hits_seen++;
                if (s)
                    sats_seen++;
            end
            expected_q = {expected_q, r};
        endfunction

        function void check_result(pair_result_t act);
            pair_result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with no pair outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (act.fx !== e.fx || act.fy !== e.fy || act.fz !== e.fz ||
                act.pot !== e.pot || act.vir !== e.vir ||
                act.hit !== e.hit || act.sat !== e.sat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: exp f=%0d,%0d,%0d pot=%0d vir=%0d hit=%b sat=%b",
                              " / got f=%0d,%0d,%0d pot=%0d vir=%0d hit=%b sat=%b"},
                             e.fx, e.fy, e.fz, e.pot, e.vir, e.hit, e.sat,
                             act.fx, act.fy, act.fz, act.pot, act.vir, act.hit, act.sat);
            end
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    cfg_idx_t           cfg_index = CFG_BOX_X;
    logic [30:0]        cfg_data = '0;
    logic               in_valid = 0;
    logic               in_ready;
    logic signed [31:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic signed [31:0] force_x, force_y, force_z, potential, virial;
    logic               in_range, saturated;

    pair_force_board board = new();

    bit quiet;      // no idling on either side
    bit hold_req;   // ask the receiver for one long hold-off
    int idle_count;

    lj_pair_force_periodic dut (.*);

    always #1 clk = ~clk;

    // Monitor: every transfer on the three channels, sampled at the edge.
    always @(posedge clk)
    begin
        logic signed [31:0] pa[3];
        logic signed [31:0] pb[3];
        pair_result_t act;
        if (cfg_valid && cfg_ready)
            board.set_reg(cfg_index, cfg_data);
        if (in_valid && in_ready)
        begin
            pa = '{ax, ay, az};
            pb = '{bx, by, bz};
            board.note_pair(pa, pb);
        end
        if (out_valid && out_ready)
        begin
            act.fx  = force_x;
            act.fy  = force_y;
            act.fz  = force_z;
            act.pot = potential;
            act.vir = virial;
            act.hit = in_range;
            act.sat = saturated;
            board.check_result(act);
        end
    end

    // Watchdog: a run that stops moving is a failure.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", board.expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random stall per result, one long hold-off on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_ready <= 0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                out_ready <= 0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Leaves cfg_valid high; the caller drops it after its last write.
    task automatic write_reg(cfg_idx_t idx, logic [30:0] v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic send_pair(logic signed [31:0] a0, a1, a2, b0, b1, b2);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        ax <= a0; ay <= a1; az <= a2;
        bx <= b0; by <= b1; bz <= b2;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering, wait for every result, then let the pipe settle.
    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(logic [30:0] bxl, byl, bzl, cut);
        drain();
        write_reg(CFG_BOX_X, bxl);
        write_reg(CFG_BOX_Y, byl);
        write_reg(CFG_BOX_Z, bzl);
        write_reg(CFG_CUTOFF_SQ, cut);
        cfg_valid <= 0;
    endtask

    // Mostly close pairs with random content, some across the box edge, some noise.
    task automatic random_pairs(int n, int span);
        logic signed [31:0] a[3];
        logic signed [31:0] b[3];
        int kind;
        for (int k = 0; k < n; k++)
        begin
            kind = $urandom_range(0, 9);
            for (int i = 0; i < 3; i++)
            begin
                a[i] = $urandom;
                if (kind == 0)
                    b[i] = $urandom;
                else
                begin
                    b[i] = a[i] - ($urandom_range(0, 2 * span) - span);
                    if (kind <= 3 && $urandom_range(0, 1))
                        b[i] = b[i] + 32'(($urandom_range(0, 1)) ? board.box[i]
                                                                 : -board.box[i]);
                end
            end
            if (kind == 9)
                b = a;  // zero distance
            send_pair(a[0], a[1], a[2], b[0], b[1], b[2]);
        end
    endtask

    initial
    begin
        quiet = 0;
        hold_req = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed pairs at reset geometry
        send_pair(0, 0, 0, 0, 0, 0);                                 // zero distance
        send_pair(32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 0);
        send_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_pair(32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0);         // far displacement
        send_pair(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0);
        send_pair(0, 32'sh7fffffff, 0, 0, 32'sh80000000, 0);
        send_pair(0, 0, 32'sh80000000, 0, 0, 32'sh7fffffff);
        send_pair(65536, 0, 0, 0, 0, 0);                             // r = 1
        send_pair(0, 0, 0, 65536, 0, 0);
        send_pair(0, 73000, 0, 0, 0, 0);                             // near cutoff
        send_pair(0, 0, 74000, 0, 0, 0);                             // beyond cutoff
        send_pair(1, 0, 0, 0, 0, 0);                                 // tiny distance
        send_pair(0, 200, 0, 0, 0, 0);
        send_pair(366356, 0, 0, 0, 0, 0);                            // exactly half box
        send_pair(366357, 0, 0, 0, 0, 0);                            // just over half
        send_pair(732712 - 65536, 0, 0, 0, 0, 0);                    // wraps to -1
        send_pair(0, 0, 0, 732712 - 65536, 0, 0);                    // wraps to +1
        send_pair(40000, -30000, 20000, 0, 0, 0);
        send_pair(-20000, 30000, -40000, 0, 0, 0);

        // default geometry, receiver holds off while pairs keep coming
        hold_req = 1;
        random_pairs(300, 100000);

        // zero box, widest cutoff; sender pauses until all results are in
        set_geometry(0, 0, 0, 31'h7fffffff);
        random_pairs(100, 20000000);

        // widest box, zero cutoff: nothing is in range
        set_geometry(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0);
        random_pairs(50, 100000);

        // small uneven boxes, first with no idling on either side, then with idling
        set_geometry(131072, 196608, 327680, 262144);
        quiet = 1;
        random_pairs(150, 200000);
        quiet = 0;
        random_pairs(150, 200000);

        // random geometry
        set_geometry(31'($urandom_range(65536, 2000000)), 31'($urandom_range(65536, 2000000)),
                     31'($urandom_range(65536, 2000000)), 31'($urandom_range(20000, 400000)));
        random_pairs(200, 150000);

        drain();
        $display("%0d pairs checked, %0d in range, %0d saturated, over five geometries",
                 board.pairs_seen, board.hits_seen, board.sats_seen);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
